[src/assert_macros.svh]
// Assertion helpers used by the bound checker in src/ghp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ghp_pkg.sv]
`default_nettype none

package ghp_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam logic [7:0] ID1_VAL        = 8'h1f;
    localparam logic [7:0] ID2_VAL        = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'd8;

    localparam int FL_EXTRA_BIT   = 2;
    localparam int FL_NAME_BIT    = 3;
    localparam int FL_COMMENT_BIT = 4;
    localparam logic [7:0] FL_RESERVED_MASK = 8'he0;

    localparam logic [3:0]  FIXED_LAST = 4'd9;
    localparam logic [15:0] STR_MAX    = 16'hffff;

    localparam logic [2:0] PH_FIXED   = 3'd0;
    localparam logic [2:0] PH_XLO     = 3'd1;
    localparam logic [2:0] PH_XHI     = 3'd2;
    localparam logic [2:0] PH_EXTRA   = 3'd3;
    localparam logic [2:0] PH_NAME    = 3'd4;
    localparam logic [2:0] PH_COMMENT = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_IGNORE  = 3'd7;

    localparam logic [3:0] K_FIXED       = 4'd0;
    localparam logic [3:0] K_XLEN        = 4'd1;
    localparam logic [3:0] K_EXTRA       = 4'd2;
    localparam logic [3:0] K_NAME        = 4'd3;
    localparam logic [3:0] K_NAME_END    = 4'd4;
    localparam logic [3:0] K_COMMENT     = 4'd5;
    localparam logic [3:0] K_COMMENT_END = 4'd6;
    localparam logic [3:0] K_PAYLOAD     = 4'd7;
    localparam logic [3:0] K_IGNORED     = 4'd8;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_ID       = 3'd1;
    localparam logic [2:0] ST_RESERVED     = 3'd2;
    localparam logic [2:0] ST_BAD_METHOD   = 3'd3;
    localparam logic [2:0] ST_UNTERMINATED = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       member_start;
        logic       stream_end;
        logic       is_zero;
        logic       id1_match;
        logic       id2_match;
        logic       method_match;
    } ghp_item_t;

    typedef struct packed {
        logic [7:0]  flags_seen;
        logic [2:0]  header_status;
        logic        status_valid;
        logic [15:0] string_pos;
        logic [7:0]  out_byte;
        logic [3:0]  byte_kind;
    } ghp_result_t;

endpackage

`default_nettype wire

[src/ghp_front.sv]
`default_nettype none

module ghp_front
    import ghp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_member_start,
    input  wire logic       in_stream_end,
    output logic            push,
    output ghp_item_t       push_item,
    input  wire logic       queue_full
);

    logic      valid_reg;
    logic      valid_next;
    ghp_item_t item_reg;

    assign push      = valid_reg && !queue_full;
    assign in_ready  = !valid_reg || !queue_full;
    assign push_item = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg.data         <= in_byte;
            item_reg.member_start <= in_member_start;
            item_reg.stream_end   <= in_stream_end;
            item_reg.is_zero      <= (in_byte == 8'd0);
            item_reg.id1_match    <= (in_byte == ID1_VAL);
            item_reg.id2_match    <= (in_byte == ID2_VAL);
            item_reg.method_match <= (in_byte == METHOD_DEFLATE);
        end
    end

endmodule

`default_nettype wire

[src/ghp_fifo.sv]
`default_nettype none

module ghp_fifo
    import ghp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire ghp_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output ghp_item_t      pop_item,
    output logic           not_empty
);

    localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CntW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

    ghp_item_t       entry_reg [FIFO_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CntFull);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[src/ghp_back.sv]
`default_nettype none

module ghp_back
    import ghp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  item_valid,
    input  wire ghp_item_t item,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output ghp_result_t out_result
);

    function automatic logic [2:0] after_extra(input logic [7:0] flags);
        if (flags[FL_NAME_BIT]) begin
            return PH_NAME;
        end else if (flags[FL_COMMENT_BIT]) begin
            return PH_COMMENT;
        end
        return PH_PAYLOAD;
    endfunction

    function automatic logic [2:0] after_name(input logic [7:0] flags);
        return flags[FL_COMMENT_BIT] ? PH_COMMENT : PH_PAYLOAD;
    endfunction

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [3:0]  fixed_index_reg;
    logic [3:0]  fixed_index_next;
    logic [7:0]  flags_reg;
    logic [7:0]  flags_next;
    logic        id_ok_reg;
    logic        id_ok_next;
    logic        method_ok_reg;
    logic        method_ok_next;
    logic [15:0] extra_left_reg;
    logic [15:0] extra_left_next;
    logic [15:0] string_count_reg;
    logic [15:0] string_count_next;
    logic        error_latch_reg;
    logic        error_latch_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    ghp_result_t result_reg;
    ghp_result_t result_next;

    assign pop        = item_valid && (!m_valid_reg || out_ready);
    assign out_valid  = m_valid_reg;
    assign out_result = result_reg;

    always_comb begin
        logic [3:0]  kind;
        logic [15:0] pos;
        logic        sv;
        logic [2:0]  st;

        phase_next        = phase_reg;
        fixed_index_next  = fixed_index_reg;
        flags_next        = flags_reg;
        id_ok_next        = id_ok_reg;
        method_ok_next    = method_ok_reg;
        extra_left_next   = extra_left_reg;
        string_count_next = string_count_reg;
        error_latch_next  = error_latch_reg;

        if (item.member_start) begin
            phase_next        = PH_FIXED;
            fixed_index_next  = '0;
            flags_next        = '0;
            id_ok_next        = 1'b1;
            method_ok_next    = 1'b1;
            extra_left_next   = '0;
            string_count_next = '0;
            error_latch_next  = 1'b0;
        end
        if (error_latch_next) begin
            phase_next = PH_IGNORE;
        end

        kind = K_IGNORED;
        pos  = '0;
        sv   = 1'b0;
        st   = ST_OK;

        case (phase_next)
            PH_FIXED: begin
                kind = K_FIXED;
                if (fixed_index_next == 4'd0 && !item.id1_match) begin
                    id_ok_next = 1'b0;
                end
                if (fixed_index_next == 4'd1 && !item.id2_match) begin
                    id_ok_next = 1'b0;
                end
                if (fixed_index_next == 4'd2 && !item.method_match) begin
                    method_ok_next = 1'b0;
                end
                if (fixed_index_next == 4'd3) begin
                    flags_next = item.data;
                end
                if (fixed_index_next >= FIXED_LAST) begin
                    sv = 1'b1;
                    if (!id_ok_next) begin
                        st = ST_BAD_ID;
                    end else if ((flags_next & FL_RESERVED_MASK) != 8'd0) begin
                        st = ST_RESERVED;
                    end else if (!method_ok_next) begin
                        st = ST_BAD_METHOD;
                    end
                    if (st != ST_OK) begin
                        error_latch_next = 1'b1;
                        phase_next       = PH_IGNORE;
                    end else if (flags_next[FL_EXTRA_BIT]) begin
                        phase_next = PH_XLO;
                    end else begin
                        phase_next = after_extra(flags_next);
                    end
                    string_count_next = '0;
                end else begin
                    fixed_index_next = fixed_index_next + 4'd1;
                end
            end
            PH_XLO: begin
                kind            = K_XLEN;
                extra_left_next = {8'd0, item.data};
                phase_next      = PH_XHI;
            end
            PH_XHI: begin
                kind              = K_XLEN;
                extra_left_next   = {item.data, extra_left_next[7:0]};
                phase_next        = (extra_left_next == 16'd0) ? after_extra(flags_next)
                                                               : PH_EXTRA;
                string_count_next = '0;
            end
            PH_EXTRA: begin
                kind            = K_EXTRA;
                extra_left_next = extra_left_next - 16'd1;
                if (extra_left_next == 16'd0) begin
                    phase_next = after_extra(flags_next);
                end
                string_count_next = '0;
            end
            PH_NAME: begin
                pos = string_count_next;
                if (item.is_zero) begin
                    kind              = K_NAME_END;
                    string_count_next = '0;
                    phase_next        = after_name(flags_next);
                end else begin
                    kind = K_NAME;
                    if (string_count_next != STR_MAX) begin
                        string_count_next = string_count_next + 16'd1;
                    end
                end
            end
            PH_COMMENT: begin
                pos = string_count_next;
                if (item.is_zero) begin
                    kind              = K_COMMENT_END;
                    string_count_next = '0;
                    phase_next        = PH_PAYLOAD;
                end else begin
                    kind = K_COMMENT;
                    if (string_count_next != STR_MAX) begin
                        string_count_next = string_count_next + 16'd1;
                    end
                end
            end
            PH_PAYLOAD: begin
                kind = K_PAYLOAD;
            end
            default: begin
                kind       = K_IGNORED;
                phase_next = PH_IGNORE;
            end
        endcase

        if (item.stream_end && !error_latch_next &&
            (phase_next inside {PH_NAME, PH_COMMENT})) begin
            sv               = 1'b1;
            st               = ST_UNTERMINATED;
            error_latch_next = 1'b1;
            phase_next       = PH_IGNORE;
        end

        result_next.byte_kind     = kind;
        result_next.out_byte      = item.data;
        result_next.string_pos    = pos;
        result_next.status_valid  = sv;
        result_next.header_status = st;
        result_next.flags_seen    = flags_next;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_FIXED;
            fixed_index_reg  <= '0;
            flags_reg        <= '0;
            id_ok_reg        <= 1'b1;
            method_ok_reg    <= 1'b1;
            extra_left_reg   <= '0;
            string_count_reg <= '0;
            error_latch_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                phase_reg        <= phase_next;
                fixed_index_reg  <= fixed_index_next;
                flags_reg        <= flags_next;
                id_ok_reg        <= id_ok_next;
                method_ok_reg    <= method_ok_next;
                extra_left_reg   <= extra_left_next;
                string_count_reg <= string_count_next;
                error_latch_reg  <= error_latch_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

[src/gzip_header_parser.sv]
// Channel   Direction  tdata (low bit up)                           tuser       tlast
// s_axis    in         [7:0] in_byte                                member_start  stream_end
// m_axis    out        [7:0] out_byte, [23:8] string_pos,           [3:0]         unused
//                      [24] status_valid, [27:25] header_status,    byte_kind
//                      [35:28] flags_seen, [39:36] zero
//
// One word is accepted and one result word is delivered per cycle, sustained, while m_axis does not stall.
// That rate is set by the parser state loop in the back end, which retires one byte a cycle unless stalled.
// An accepted word is held in the front register, the queue and the back-end result register before m_axis.
// A two-entry queue between the classifier and the parser absorbs stalls on either side.
// Synchronous active-low reset clears the parser state and empties every stage.
`default_nettype none

module gzip_header_parser
    import ghp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tuser,   // member_start
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // out_byte, string_pos, status_valid,
                                             // header_status, flags_seen, zero fill
    output logic [3:0]       m_axis_tuser,   // byte_kind
    output logic             m_axis_tlast
);

    logic        push;
    ghp_item_t   push_item;
    logic        queue_full;
    logic        pop;
    ghp_item_t   head_item;
    logic        head_valid;
    ghp_result_t result;

    ghp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_byte         (s_axis_tdata),
        .in_member_start (s_axis_tuser),
        .in_stream_end   (s_axis_tlast),
        .push            (push),
        .push_item       (push_item),
        .queue_full      (queue_full)
    );

    ghp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (head_item),
        .not_empty (head_valid)
    );

    ghp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (head_valid),
        .item       (head_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {4'd0, result.flags_seen, result.header_status,
                           result.status_valid, result.string_pos, result.out_byte};
    assign m_axis_tuser = result.byte_kind;
    assign m_axis_tlast = 1'b0;

endmodule

`default_nettype wire

[src/ghp_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module ghp_checker
    import ghp_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tuser,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [3:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")
    `ASSERT_CLK(a_status_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[24] |-> m_axis_tdata[27:25] == ST_OK, "status without status_valid")
    `ASSERT_CLK(a_pos_zero, aclk, aresetn, m_axis_tvalid && !(m_axis_tuser == K_NAME || m_axis_tuser == K_NAME_END || m_axis_tuser == K_COMMENT || m_axis_tuser == K_COMMENT_END) |-> m_axis_tdata[23:8] == 16'd0, "string position on a non-string word")
    `ASSERT_CLK(a_kind_range, aclk, aresetn, m_axis_tvalid |-> m_axis_tuser <= K_IGNORED && m_axis_tdata[39:36] == 4'd0 && !m_axis_tlast, "bad byte kind or fill bits")
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_axis_tvalid, "result word valid after reset")

endmodule

bind gzip_header_parser ghp_checker u_ghp_checker (.*);

`default_nettype wire

[bench/ghp_checker.sv]
module ghp_label_checker
    import ghp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tuser,   // member_start
    input  wire logic        s_axis_tlast,   // stream_end
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // out_byte, string_pos, status_valid,
                                             // header_status, flags_seen, zero fill
    input  wire logic [3:0]  m_axis_tuser,   // byte_kind
    output int               mismatches,
    output int               labels_pending,
    output int               words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]  sect;
    logic [3:0]  hdr_idx;
    logic [7:0]  flags;
    logic        id_good;
    logic        method_good;
    logic [15:0] extra_cnt;
    logic [15:0] str_cnt;
    logic        latched;

    ghp_result_t label_q[$];

    function automatic void clear_parser();
        sect        = PH_FIXED;
        hdr_idx     = '0;
        flags       = '0;
        id_good     = 1'b1;
        method_good = 1'b1;
        extra_cnt   = '0;
        str_cnt     = '0;
        latched     = 1'b0;
    endfunction

    // Section that follows the extra field, or the name when name_allowed is low.
    function automatic logic [2:0] next_section(input logic name_allowed);
        if (name_allowed && flags[FL_NAME_BIT]) return PH_NAME;
        if (flags[FL_COMMENT_BIT]) return PH_COMMENT;
        return PH_PAYLOAD;
    endfunction

    function automatic ghp_result_t label_byte(input logic [7:0] b, input logic start,
                                               input logic last);
        ghp_result_t r;
        r = '0;
        r.out_byte  = b;
        r.byte_kind = K_IGNORED;
        if (start) clear_parser();
        if (latched) sect = PH_IGNORE;
        case (sect)
            PH_FIXED: begin
                r.byte_kind = K_FIXED;
                if (hdr_idx == 4'd0 && b != ID1_VAL) id_good = 1'b0;
                if (hdr_idx == 4'd1 && b != ID2_VAL) id_good = 1'b0;
                if (hdr_idx == 4'd2 && b != METHOD_DEFLATE) method_good = 1'b0;
                if (hdr_idx == 4'd3) flags = b;
                if (hdr_idx >= FIXED_LAST) begin
                    r.status_valid = 1'b1;
                    if (!id_good) r.header_status = ST_BAD_ID;
                    else if ((flags & FL_RESERVED_MASK) != 8'd0) r.header_status = ST_RESERVED;
                    else if (!method_good) r.header_status = ST_BAD_METHOD;
                    else r.header_status = ST_OK;
                    if (r.header_status != ST_OK) begin
                        latched = 1'b1;
                        sect    = PH_IGNORE;
                    end else if (flags[FL_EXTRA_BIT]) begin
                        sect = PH_XLO;
                    end else begin
                        sect = next_section(1'b1);
                    end
                    str_cnt = '0;
                end else begin
                    hdr_idx = hdr_idx + 4'd1;
                end
            end
            PH_XLO: begin
                r.byte_kind = K_XLEN;
                extra_cnt   = {8'd0, b};
                sect        = PH_XHI;
            end
            PH_XHI: begin
                r.byte_kind = K_XLEN;
                extra_cnt   = {b, extra_cnt[7:0]};
                sect        = (extra_cnt == 16'd0) ? next_section(1'b1) : PH_EXTRA;
                str_cnt     = '0;
            end
            PH_EXTRA: begin
                r.byte_kind = K_EXTRA;
                extra_cnt   = extra_cnt - 16'd1;
                if (extra_cnt == 16'd0) sect = next_section(1'b1);
                str_cnt = '0;
            end
            PH_NAME, PH_COMMENT: begin
                r.string_pos = str_cnt;
                if (b == 8'd0) begin
                    r.byte_kind = (sect == PH_NAME) ? K_NAME_END : K_COMMENT_END;
                    str_cnt     = '0;
                    sect        = (sect == PH_NAME) ? next_section(1'b0) : PH_PAYLOAD;
                end else begin
                    r.byte_kind = (sect == PH_NAME) ? K_NAME : K_COMMENT;
                    if (str_cnt != STR_MAX) str_cnt = str_cnt + 16'd1;
                end
            end
            PH_PAYLOAD: r.byte_kind = K_PAYLOAD;
            default: begin
                r.byte_kind = K_IGNORED;
                sect        = PH_IGNORE;
            end
        endcase
        // A stream that stops inside an open or pending string is reported here.
        if (last && !latched && (sect == PH_NAME || sect == PH_COMMENT)) begin
            r.status_valid  = 1'b1;
            r.header_status = ST_UNTERMINATED;
            latched         = 1'b1;
            sect            = PH_IGNORE;
        end
        r.flags_seen = flags;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        ghp_result_t want;
        if (!aresetn) begin
            clear_parser();
            label_q.delete();
            mismatches    = 0;
            words_checked = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                label_q.push_back(label_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready) begin
                if (label_q.size() == 0) begin
                    $error("result word %h with no word outstanding", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = label_q.pop_front();
                    words_checked++;
                    check_field("byte_kind", 16'(want.byte_kind), 16'(m_axis_tuser));
                    check_field("out_byte", 16'(want.out_byte), 16'(m_axis_tdata[7:0]));
                    check_field("string_pos", want.string_pos, m_axis_tdata[23:8]);
                    check_field("status_valid", 16'(want.status_valid), 16'(m_axis_tdata[24]));
                    check_field("header_status", 16'(want.header_status),
                                16'(m_axis_tdata[27:25]));
                    check_field("flags_seen", 16'(want.flags_seen), 16'(m_axis_tdata[35:28]));
                end
            end
        end
        labels_pending <= label_q.size();
    end

endmodule

[bench/tb_gzip_header_parser.sv]
module tb_gzip_header_parser;
    import ghp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 400;
    localparam int STALL_LIMIT     = 5000;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int mismatches;
    int labels_pending;
    int words_checked;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int words_sent   = 0;
    int quiet_cycles = 0;

    gzip_header_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    ghp_label_checker label_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .mismatches(mismatches), .labels_pending(labels_pending),
        .words_checked(words_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic start, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        words_sent++;
    endtask

    // Sends one member with random content.
    task automatic send_member();
        logic [7:0] body[$];
        logic [7:0] flg;
        int         n;
        int         fault;
        int         cut;
        flg   = 8'($urandom_range(0, 31));
        fault = $urandom_range(0, 19);
        body.push_back(fault == 0 ? 8'($urandom) : ID1_VAL);
        body.push_back(fault == 1 ? 8'($urandom) : ID2_VAL);
        body.push_back(fault == 2 ? 8'($urandom) : METHOD_DEFLATE);
        if (fault == 3) flg[7:5] = 3'($urandom_range(1, 7));
        body.push_back(flg);
        repeat (6) body.push_back(8'($urandom));
        if (flg[FL_EXTRA_BIT]) begin
            n = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
            body.push_back(n[7:0]);
            body.push_back(n[15:8]);
            repeat (n) body.push_back(8'($urandom));
        end
        if (flg[FL_NAME_BIT]) begin
            repeat ($urandom_range(0, 8)) body.push_back(8'($urandom_range(1, 255)));
            body.push_back(8'd0);
        end
        if (flg[FL_COMMENT_BIT]) begin
            repeat ($urandom_range(0, 8)) body.push_back(8'($urandom_range(1, 255)));
            body.push_back(8'd0);
        end
        repeat ($urandom_range(0, 12)) body.push_back(8'($urandom));
        n = $urandom_range(0, 19);
        if (n < 12) cut = body.size() - 1;
        else if (n < 16) cut = $urandom_range(0, body.size() - 1);
        else cut = -1;
        for (int i = 0; i < body.size(); i++) send_word(body[i], i == 0, i == cut);
    endtask

    initial begin : stimulus
        int phase_start;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Member with every optional section: two extra bytes, one-letter name,
        // empty comment, payload that ends the stream.
        send_word(ID1_VAL, 1'b1, 1'b0);
        send_word(ID2_VAL, 1'b0, 1'b0);
        send_word(METHOD_DEFLATE, 1'b0, 1'b0);
        send_word(8'h1c, 1'b0, 1'b0);
        repeat (5) send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h02, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hab, 1'b0, 1'b0);
        send_word(8'hcd, 1'b0, 1'b0);
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // The stream ends on the OS byte while a name is still expected.
        send_word(ID1_VAL, 1'b1, 1'b0);
        send_word(ID2_VAL, 1'b0, 1'b0);
        send_word(METHOD_DEFLATE, 1'b0, 1'b0);
        send_word(8'h08, 1'b0, 1'b0);
        repeat (5) send_word(8'h5a, 1'b0, 1'b0);
        send_word(8'h03, 1'b0, 1'b1);
        send_word(8'h55, 1'b0, 1'b0);

        for (int p = 0; p < 3; p++) begin
            src_idle_pct = (p == 0) ? 32 : (p == 1) ? 53 : 0;
            snk_idle_pct = (p == 0) ? 53 : (p == 1) ? 32 : 0;
            phase_start = words_sent;
            while (words_sent - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 19) == 0) begin
                    repeat ($urandom_range(1, 8))
                        send_word(8'($urandom), ($urandom_range(0, 3) == 0),
                                  ($urandom_range(0, 3) == 0));
                end else begin
                    send_member();
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (labels_pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("Sent %0d words and compared %0d labeled words.", words_sent, words_checked);
        $display("Covered clean and faulty headers, extra fields, strings, truncation %s",
                 "and noise.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[gzip_header_parser.f]
+incdir+src
src/ghp_pkg.sv
src/ghp_front.sv
src/ghp_fifo.sv
src/ghp_back.sv
src/gzip_header_parser.sv
src/ghp_checker.sv
bench/ghp_checker.sv
bench/tb_gzip_header_parser.sv
